// File: design/gput_pkg.sv
package gput_pkg;

    localparam int OP_W  = 2;
    localparam int SEL_W = 3;
    localparam int DATA_W = 16;
    localparam int CTL_W = 5;
    localparam int PSC_W = 16;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [SEL_W-1:0] REG_CTRL   = 3'd0;
    localparam logic [SEL_W-1:0] REG_IER    = 3'd1;
    localparam logic [SEL_W-1:0] REG_STATUS = 3'd2;
    localparam logic [SEL_W-1:0] REG_CNT    = 3'd3;
    localparam logic [SEL_W-1:0] REG_PSC    = 3'd4;
    localparam logic [SEL_W-1:0] REG_ARR    = 3'd5;

    localparam int CTL_EN   = 0;
    localparam int CTL_UDIS = 1;
    localparam int CTL_URS  = 2;
    localparam int CTL_OPM  = 3;
    localparam int CTL_DIR  = 4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SEL_W-1:0]  reg_sel;
        logic [DATA_W-1:0] wdata;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              irq;
        logic              update_event;
    } rsp_t;

endpackage

// File: design/gput_if.sv
interface gput_cmd_if;
    import gput_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SEL_W-1:0]  reg_sel;
    logic [DATA_W-1:0] wdata;

    modport source (output valid, output op, output reg_sel, output wdata, input ready);
    modport sink   (input valid, input op, input reg_sel, input wdata, output ready);
endinterface

interface gput_rsp_if;
    import gput_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] rdata;
    logic              irq;
    logic              update_event;

    modport source (output valid, output rdata, output irq, output update_event, input ready);
    modport sink   (input valid, input rdata, input irq, input update_event, output ready);
endinterface

// File: design/gput_core.sv
module gput_core
    import gput_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  cmd_t cmd,
    output rsp_t result
);

    logic [CTL_W-1:0]       ctl_reg, ctl_next;
    logic                   ier_reg, ier_next;
    logic                   flag_reg, flag_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [PSC_W-1:0]       psc_cnt_reg, psc_cnt_next;
    logic [PSC_W-1:0]       psc_val_reg, psc_val_next;
    logic [COUNT_WIDTH-1:0] arr_reg, arr_next;

    logic [COUNT_WIDTH+DATA_W-1:0] wdata_ext;
    logic [COUNT_WIDTH+DATA_W-1:0] cnt_ext;
    logic [COUNT_WIDTH+DATA_W-1:0] arr_ext;
    logic [DATA_W-1:0]             rdata;
    logic                          ev;

    assign wdata_ext = {{COUNT_WIDTH{1'b0}}, cmd.wdata};
    assign cnt_ext   = {{DATA_W{1'b0}}, cnt_reg};
    assign arr_ext   = {{DATA_W{1'b0}}, arr_reg};

    always_comb
    begin
        ctl_next     = ctl_reg;
        ier_next     = ier_reg;
        flag_next    = flag_reg;
        cnt_next     = cnt_reg;
        psc_cnt_next = psc_cnt_reg;
        psc_val_next = psc_val_reg;
        arr_next     = arr_reg;
        rdata        = '0;
        ev           = 1'b0;
        unique case (cmd.op)
            OP_TICK:
            begin
                if (ctl_reg[CTL_EN])
                begin
                    if (psc_cnt_reg < psc_val_reg)
                    begin
                        psc_cnt_next = psc_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        psc_cnt_next = '0;
                        if (cnt_reg == arr_reg)
                        begin
                            cnt_next = '0;
                            if (!ctl_reg[CTL_UDIS])
                            begin
                                flag_next = 1'b1;
                                ev        = 1'b1;
                                if (ctl_reg[CTL_OPM])
                                begin
                                    ctl_next[CTL_EN] = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
            end
            OP_WRITE:
            begin
                unique case (cmd.reg_sel)
                    REG_CTRL:   ctl_next     = cmd.wdata[CTL_W-1:0];
                    REG_IER:    ier_next     = cmd.wdata[0];
                    REG_STATUS: flag_next    = flag_reg & cmd.wdata[0];
                    REG_CNT:    cnt_next     = wdata_ext[COUNT_WIDTH-1:0];
                    REG_PSC:    psc_val_next = cmd.wdata;
                    REG_ARR:    arr_next     = wdata_ext[COUNT_WIDTH-1:0];
                    default:    ;
                endcase
            end
            OP_READ:
            begin
                unique case (cmd.reg_sel)
                    REG_CTRL:   rdata = {{(DATA_W-CTL_W){1'b0}}, ctl_reg};
                    REG_IER:    rdata = {{(DATA_W-1){1'b0}}, ier_reg};
                    REG_STATUS: rdata = {{(DATA_W-1){1'b0}}, flag_reg};
                    REG_CNT:    rdata = cnt_ext[DATA_W-1:0];
                    REG_PSC:    rdata = psc_val_reg;
                    REG_ARR:    rdata = arr_ext[DATA_W-1:0];
                    default:    rdata = '0;
                endcase
            end
            default: ;
        endcase
    end

    assign result.rdata        = rdata;
    assign result.irq          = flag_next & ier_next;
    assign result.update_event = ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg     <= '0;
            ier_reg     <= 1'b0;
            flag_reg    <= 1'b0;
            cnt_reg     <= '0;
            psc_cnt_reg <= '0;
            psc_val_reg <= '0;
            arr_reg     <= '1;
        end
        else if (accept)
        begin
            ctl_reg     <= ctl_next;
            ier_reg     <= ier_next;
            flag_reg    <= flag_next;
            cnt_reg     <= cnt_next;
            psc_cnt_reg <= psc_cnt_next;
            psc_val_reg <= psc_val_next;
            arr_reg     <= arr_next;
        end
    end

    a_event_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.update_event |=> flag_reg && cnt_reg == '0)
        else $error("update event did not set flag and clear counter");

    a_disabled_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.op == OP_TICK && !ctl_reg[CTL_EN] |=> $stable(cnt_reg)
            && $stable(psc_cnt_reg) && $stable(flag_reg))
        else $error("disabled tick changed timer state");

    a_opm_stops: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.update_event && ctl_reg[CTL_OPM] |=> !ctl_reg[CTL_EN])
        else $error("one-pulse event left timer enabled");

    a_prescale_holds_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.op == OP_TICK && psc_cnt_reg < psc_val_reg |=> $stable(cnt_reg))
        else $error("counter stepped inside prescale period");

endmodule

// File: design/general_purpose_upcount_timer.sv
// Channel  Dir  Payload                         Handshake
// cmd      in   op[1:0] reg_sel[2:0] wdata[15:0] valid/ready
// rsp      out  rdata[15:0] irq update_event    valid/ready
//
// One cmd beat yields one rsp beat; state updates in the accepting cycle.
// The response appears the cycle after the cmd beat, from the output register.
// Throughput is one beat per cycle; cmd.ready = !rsp.valid || rsp.ready.
// A stalled rsp holds its beat and blocks cmd only while it is full.
// rst_n resets all but the rsp payload; reload to all ones, the rest to zero.
module general_purpose_upcount_timer
    import gput_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    gput_cmd_if.sink    cmd,
    gput_rsp_if.source  rsp
);

    cmd_t cmd_beat;
    rsp_t result;
    rsp_t rsp_reg;
    logic rsp_valid_reg, rsp_valid_next;
    logic accept;

    assign cmd_beat.op      = cmd.op;
    assign cmd_beat.reg_sel = cmd.reg_sel;
    assign cmd_beat.wdata   = cmd.wdata;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    gput_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd_beat),
        .result (result)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.rdata        = rsp_reg.rdata;
    assign rsp.irq          = rsp_reg.irq;
    assign rsp.update_event = rsp_reg.update_event;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted beat produced no response");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |-> !accept)
        else $error("cmd accepted over a stalled response");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp.ready && !accept |=> !rsp_valid_reg)
        else $error("response repeated after it was taken");

endmodule

// File: tb/gput_response_check.sv
module gput_response_check
    import gput_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    gput_cmd_if  cmd_mon,
    gput_rsp_if  rsp_mon,
    output int   failures,
    output int   pending
);

    logic [CTL_W-1:0]       ctl;
    logic                   irq_en;
    logic                   upd_flag;
    logic [COUNT_WIDTH-1:0] count;
    logic [PSC_W-1:0]       psc_count;
    logic [PSC_W-1:0]       psc_value;
    logic [COUNT_WIDTH-1:0] reload;

    rsp_t expected_rsp_q[$];
    cmd_t seen_cmd;
    rsp_t want;
    rsp_t got;

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    task automatic report_mismatch(input string what, input int unsigned seen,
                                   input int unsigned exp_val);
        $display("%0t: %s got %0h, want %0h", $time, what, seen, exp_val);
        failures++;
    endtask

    // Advance the timer state by one beat and return the response it yields.
    task automatic timer_apply(input cmd_t c, output rsp_t r);
        logic ev;
        ev = 1'b0;
        r  = '0;
        case (c.op)
            OP_TICK:
                if (ctl[CTL_EN])
                begin
                    if (psc_count < psc_value)
                    begin
                        psc_count = psc_count + 1'b1;
                    end
                    else
                    begin
                        psc_count = '0;
                        if (count == reload)
                        begin
                            count = '0;
                            if (!ctl[CTL_UDIS])
                            begin
                                upd_flag = 1'b1;
                                ev       = 1'b1;
                                if (ctl[CTL_OPM])
                                    ctl[CTL_EN] = 1'b0;
                            end
                        end
                        else
                        begin
                            count = count + 1'b1;
                        end
                    end
                end
            OP_WRITE:
                case (c.reg_sel)
                    REG_CTRL:   ctl       = c.wdata[CTL_W-1:0];
                    REG_IER:    irq_en    = c.wdata[0];
                    REG_STATUS: upd_flag  = upd_flag & c.wdata[0];
                    REG_CNT:    count     = COUNT_WIDTH'(c.wdata);
                    REG_PSC:    psc_value = c.wdata[PSC_W-1:0];
                    REG_ARR:    reload    = COUNT_WIDTH'(c.wdata);
                    default:    ;
                endcase
            OP_READ:
                case (c.reg_sel)
                    REG_CTRL:   r.rdata = DATA_W'(ctl);
                    REG_IER:    r.rdata = DATA_W'(irq_en);
                    REG_STATUS: r.rdata = DATA_W'(upd_flag);
                    REG_CNT:    r.rdata = DATA_W'(count);
                    REG_PSC:    r.rdata = DATA_W'(psc_value);
                    REG_ARR:    r.rdata = DATA_W'(reload);
                    default:    r.rdata = '0;
                endcase
            default: ;
        endcase
        r.irq          = upd_flag & irq_en;
        r.update_event = ev;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl       = '0;
            irq_en    = 1'b0;
            upd_flag  = 1'b0;
            count     = '0;
            psc_count = '0;
            psc_value = '0;
            reload    = '1;
            expected_rsp_q.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got.rdata        = rsp_mon.rdata;
                got.irq          = rsp_mon.irq;
                got.update_event = rsp_mon.update_event;
                if (expected_rsp_q.size() == 0)
                begin
                    report_mismatch("unexpected rsp beat, rdata", 32'(got.rdata), 0);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (got.rdata !== want.rdata)
                        report_mismatch("rdata", 32'(got.rdata), 32'(want.rdata));
                    if (got.irq !== want.irq)
                        report_mismatch("irq", 32'(got.irq), 32'(want.irq));
                    if (got.update_event !== want.update_event)
                        report_mismatch("update_event", 32'(got.update_event),
                                        32'(want.update_event));
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                seen_cmd.op      = cmd_mon.op;
                seen_cmd.reg_sel = cmd_mon.reg_sel;
                seen_cmd.wdata   = cmd_mon.wdata;
                timer_apply(seen_cmd, want);
                expected_rsp_q.push_back(want);
            end
            pending <= expected_rsp_q.size();
        end
    end

endmodule

// File: tb/general_purpose_upcount_timer_tb.sv
module general_purpose_upcount_timer_tb;
    import gput_pkg::*;

    localparam int COUNT_WIDTH = 16;
    localparam int NUM_RANDOM  = 450;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [SEL_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [SEL_W-1:0] REG_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    gput_cmd_if cmd_ch();
    gput_rsp_if rsp_ch();

    int failures;
    int pending;
    int items_sent = 0;
    int cycle_count = 0;
    bit cmd_burst = 1'b0;
    bit rsp_burst = 1'b0;
    logic rsp_hold = 1'b0;

    general_purpose_upcount_timer #(.COUNT_WIDTH(COUNT_WIDTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    gput_response_check #(.COUNT_WIDTH(COUNT_WIDTH)) response_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_mon  (cmd_ch),
        .rsp_mon  (rsp_ch),
        .failures (failures),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic cmd_t mk(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                                input logic [DATA_W-1:0] data);
        cmd_t c;
        c.op      = op;
        c.reg_sel = sel;
        c.wdata   = data;
        return c;
    endfunction

    // Mostly small reload/prescale values so the counter wraps often.
    function automatic cmd_t random_cmd();
        cmd_t c;
        int kind;
        kind      = $urandom_range(0, 99);
        c.wdata   = DATA_W'($urandom_range(0, 65535));
        c.reg_sel = ($urandom_range(0, 9) == 0) ? SEL_W'($urandom_range(0, 7))
                                                : SEL_W'($urandom_range(0, 5));
        if (kind < 55)
        begin
            c.op = OP_TICK;
        end
        else if (kind < 80)
        begin
            c.op = OP_WRITE;
            case (c.reg_sel)
                REG_CTRL:
                begin
                    c.wdata[CTL_EN]   = ($urandom_range(0, 4) != 0);
                    c.wdata[CTL_UDIS] = ($urandom_range(0, 3) == 0);
                end
                REG_PSC:
                    if ($urandom_range(0, 9) != 0)
                        c.wdata = DATA_W'($urandom_range(0, 3));
                REG_ARR:
                    if ($urandom_range(0, 9) != 0)
                        c.wdata = DATA_W'($urandom_range(0, 12));
                REG_CNT:
                    if ($urandom_range(0, 4) != 0)
                        c.wdata = DATA_W'($urandom_range(0, 12));
                default: ;
            endcase
        end
        else if (kind < 96)
        begin
            c.op = OP_READ;
        end
        else
        begin
            c.op = OP_UNUSED;
        end
        return c;
    endfunction

    task automatic issue_cmd(input cmd_t c);
        int gap;
        gap = pick_wait(cmd_burst);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.op      <= c.op;
        cmd_ch.reg_sel <= c.reg_sel;
        cmd_ch.wdata   <= c.wdata;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("general_purpose_upcount_timer: mismatch");
        $finish;
    end

    // Long sink stall while the source keeps offering beats.
    initial
    begin
        while (items_sent < 150) @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    initial
    begin
        int stall;
        int beats;
        beats = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (beats % 40 == 0)
                rsp_burst = ($urandom_range(0, 3) == 0);
            stall = pick_wait(rsp_burst);
            if (stall > 0 || rsp_hold)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (rsp_hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            beats++;
        end
    end

    initial
    begin
        cmd_t directed_q[$];
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.op      = OP_TICK;
        cmd_ch.reg_sel = REG_CTRL;
        cmd_ch.wdata   = '0;

        directed_q.push_back(mk(OP_READ,  REG_ARR,    16'h0000));
        directed_q.push_back(mk(OP_WRITE, REG_CNT,    16'hFFFF));
        directed_q.push_back(mk(OP_WRITE, REG_ARR,    16'h0002));
        directed_q.push_back(mk(OP_WRITE, REG_PSC,    16'h0001));
        directed_q.push_back(mk(OP_WRITE, REG_IER,    16'hFFFF));
        // enable + one-pulse, high bits dropped
        directed_q.push_back(mk(OP_WRITE, REG_CTRL,   16'hFFE9));
        // counter starts above reload: wraps silently, then overflows at reload
        repeat (8) directed_q.push_back(mk(OP_TICK, REG_CTRL, 16'h0000));
        directed_q.push_back(mk(OP_READ,  REG_STATUS, 16'h0000));
        directed_q.push_back(mk(OP_READ,  REG_CTRL,   16'h0000));
        directed_q.push_back(mk(OP_WRITE, REG_STATUS, 16'hFFFF));
        directed_q.push_back(mk(OP_WRITE, REG_STATUS, 16'hFFFE));
        directed_q.push_back(mk(OP_WRITE, REG_PSC,    16'h0005));
        directed_q.push_back(mk(OP_WRITE, REG_CTRL,   16'h0017));
        directed_q.push_back(mk(OP_TICK,  REG_ARR,    16'hFFFF));
        directed_q.push_back(mk(OP_TICK,  REG_ARR,    16'hFFFF));
        // shrink prescaler below its running count
        directed_q.push_back(mk(OP_WRITE, REG_PSC,    16'h0000));
        directed_q.push_back(mk(OP_TICK,  REG_CTRL,   16'h0000));
        directed_q.push_back(mk(OP_UNUSED, REG_SPARE_HI, 16'hFFFF));
        directed_q.push_back(mk(OP_WRITE, REG_SPARE_HI, 16'hFFFF));
        directed_q.push_back(mk(OP_READ,  REG_SPARE_LO, 16'h0000));
        directed_q.push_back(mk(OP_READ,  REG_PSC,    16'h0000));
        directed_q.push_back(mk(OP_READ,  REG_CNT,    16'h0000));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_q[i])
            issue_cmd(directed_q[i]);
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 40 == 0)
                cmd_burst = ($urandom_range(0, 2) == 0);
            issue_cmd(random_cmd());
        end
        cmd_ch.valid <= 1'b0;

        // pending is updated by a nonblocking assignment; let it catch up with the last beat
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("general_purpose_upcount_timer: match");
        else
            $display("general_purpose_upcount_timer: mismatch");
        $finish;
    end

endmodule
